@@ sv/pdt_pkg.sv @@
// Shared types and constants for the PTP Delay_Req pad trimmer.
package pdt_pkg;

  localparam int unsigned DOMAIN_W = 8;
  localparam int unsigned LEN_W    = 11;
  localparam int unsigned CFG_W    = 11;
  localparam int unsigned POS_W    = 16;

  typedef enum logic [0:0] {
    CFG_PTP_DOMAIN = 1'b0,
    CFG_PTP_LENGTH = 1'b1
  } cfg_index_t;

  localparam logic [DOMAIN_W-1:0] DOMAIN_RESET = 8'd24;
  localparam logic [LEN_W-1:0]    LENGTH_RESET = 11'd44;

  localparam logic [15:0] ETYPE_VLAN_Q  = 16'h8100;
  localparam logic [15:0] ETYPE_VLAN_AD = 16'h88a8;
  localparam logic [15:0] ETYPE_PTP     = 16'h88f7;
  localparam logic [3:0]  MSG_TYPE_DREQ = 4'h1;
  localparam logic [3:0]  PTP_VERSION_2 = 4'h2;
  localparam logic [4:0]  HDR_UNTAGGED  = 5'd14;
  localparam logic [4:0]  HDR_TAGGED    = 5'd18;
  localparam logic [LEN_W-1:0] MIN_PTP_LENGTH = 11'd5;

  typedef enum logic [1:0] {
    DEC_UNDECIDED = 2'd0,
    DEC_PASS      = 2'd1,
    DEC_TRIM      = 2'd2
  } decision_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       trimmed;
  } result_t;

endpackage

@@ sv/pdt_parser.sv @@
// Frame header parser: tracks byte position, decides trim and marks the cut byte.
module pdt_parser (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        step,
  input  logic [7:0]                  in_byte,
  input  logic                        in_end,
  input  logic [pdt_pkg::DOMAIN_W-1:0] ptp_domain,
  input  logic [pdt_pkg::LEN_W-1:0]    ptp_length,
  output logic                        emit,
  output pdt_pkg::result_t            res
);
  import pdt_pkg::*;

  logic [POS_W-1:0] pos, pos_next;
  logic             tag, tag_next;
  logic [7:0]       thb, thb_next;
  logic [7:0]       lhb, lhb_next;
  decision_t        dec, dec_next;
  logic             drop, drop_next;

  logic [15:0]      etype;
  logic [4:0]       hdr;
  logic [POS_W-1:0] k;
  logic             past_hdr;
  logic [LEN_W:0]   cut;

  always_comb begin
    pos_next  = pos;
    tag_next  = tag;
    thb_next  = thb;
    lhb_next  = lhb;
    dec_next  = dec;
    drop_next = drop;
    emit        = 1'b0;
    res.data    = in_byte;
    res.last    = in_end;
    res.trimmed = 1'b0;

    etype    = {thb, in_byte};
    hdr      = tag ? HDR_TAGGED : HDR_UNTAGGED;
    past_hdr = pos >= {11'd0, hdr};
    k        = pos - {11'd0, hdr};
    cut      = '0;

    if (!drop) begin
      emit = 1'b1;
      if (dec == DEC_UNDECIDED) begin
        if (pos == 16'd12) begin
          thb_next = in_byte;
        end else if (pos == 16'd13) begin
          if (etype == ETYPE_VLAN_Q || etype == ETYPE_VLAN_AD) begin
            tag_next = 1'b1;
          end else if (etype != ETYPE_PTP) begin
            dec_next = DEC_PASS;
          end
        end else if (tag && pos == 16'd16) begin
          thb_next = in_byte;
        end else if (tag && pos == 16'd17) begin
          if (etype != ETYPE_PTP) dec_next = DEC_PASS;
        end else if (past_hdr) begin
          if (k == 16'd0) begin
            if (in_byte[3:0] != MSG_TYPE_DREQ) dec_next = DEC_PASS;
          end else if (k == 16'd1) begin
            if (in_byte[3:0] != PTP_VERSION_2) dec_next = DEC_PASS;
          end else if (k == 16'd2) begin
            lhb_next = in_byte;
          end else if (k == 16'd3) begin
            if ({lhb, in_byte} != {5'd0, ptp_length}) dec_next = DEC_PASS;
          end else if (k == 16'd4) begin
            if (in_byte == ptp_domain && ptp_length >= MIN_PTP_LENGTH) begin
              dec_next = DEC_TRIM;
            end else begin
              dec_next = DEC_PASS;
            end
          end
        end
      end

      // cut point uses the tag state as it stands after this byte
      cut = {7'd0, (tag_next ? HDR_TAGGED : HDR_UNTAGGED)} + {1'b0, ptp_length};
      if (dec_next == DEC_TRIM && !in_end &&
          ({1'b0, pos} + 17'd1 == {5'd0, cut})) begin
        res.last    = 1'b1;
        res.trimmed = 1'b1;
        drop_next   = 1'b1;
      end

      if (pos != {POS_W{1'b1}}) pos_next = pos + 16'd1;
    end

    if (in_end) begin
      pos_next  = '0;
      tag_next  = 1'b0;
      thb_next  = '0;
      lhb_next  = '0;
      dec_next  = DEC_UNDECIDED;
      drop_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos  <= '0;
      tag  <= 1'b0;
      thb  <= '0;
      lhb  <= '0;
      dec  <= DEC_UNDECIDED;
      drop <= 1'b0;
    end else if (step) begin
      pos  <= pos_next;
      tag  <= tag_next;
      thb  <= thb_next;
      lhb  <= lhb_next;
      dec  <= dec_next;
      drop <= drop_next;
    end
  end

endmodule

@@ sv/pdt_out_stage.sv @@
// Output register holding one result item toward the master side.
module pdt_out_stage (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  pdt_pkg::result_t load_res,
  input  logic             out_ready,
  output logic             can_take,
  output logic             out_valid,
  output pdt_pkg::result_t out_res
);
  import pdt_pkg::*;

  assign can_take = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (can_take) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (can_take && load) out_res <= load_res;
  end

endmodule

@@ sv/ptp_delay_req_pad_trimmer.sv @@
// Top level: input register, header parser and output register of the pad trimmer.
//
// Frame bytes enter on the s_* stream, one byte per item, s_tlast on the final
// byte. Bytes leave unchanged on the m_* stream. For a version 2 Delay_Req in
// the configured domain whose messageLength equals the configured length, the
// frame is cut after the L2 header (14 bytes, 18 with one VLAN tag) plus that
// length: the kept last byte carries m_tlast and m_tuser (trimmed) and the
// remaining input bytes are consumed with no output. Other frames pass whole.
// An item accepted on s_* sits in the input register, moves to the output
// register when the parser steps and is offered on m_tvalid from then on.
// Throughput is one byte per cycle while m_tready does not stall, set by the
// combinational parser step. A stall on m_tready holds the output register;
// an empty input register still takes one more byte, then s_tready drops
// until the output drains. Reset (rst, synchronous) empties both registers,
// clears the frame state and loads domain 24, length 44. Configuration writes
// (cfg_we) take effect at the write edge and are to be made while no frame is
// in flight; the block leaves this to the user and does no check of its own.
module ptp_delay_req_pad_trimmer (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [7:0] out_byte
  output logic        m_tlast,
  output logic        m_tuser,   // [0] was_trimmed
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [pdt_pkg::CFG_W-1:0] cfg_data
);
  import pdt_pkg::*;

  logic [DOMAIN_W-1:0] ptp_domain;
  logic [LEN_W-1:0]    ptp_length;

  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_end;
  logic       can_take;
  logic       step;
  logic       emit;
  result_t    res;
  result_t    out_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      ptp_domain <= DOMAIN_RESET;
      ptp_length <= LENGTH_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_PTP_DOMAIN: ptp_domain <= cfg_data[DOMAIN_W-1:0];
        CFG_PTP_LENGTH: ptp_length <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign step     = in_valid && can_take;
  assign s_tready = !in_valid || can_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
      in_end  <= s_tlast;
    end
  end

  pdt_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .in_byte    (in_byte),
    .in_end     (in_end),
    .ptp_domain (ptp_domain),
    .ptp_length (ptp_length),
    .emit       (emit),
    .res        (res)
  );

  pdt_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (step && emit),
    .load_res  (res),
    .out_ready (m_tready),
    .can_take  (can_take),
    .out_valid (m_tvalid),
    .out_res   (out_res)
  );

  assign m_tdata = out_res.data;
  assign m_tlast = out_res.last;
  assign m_tuser = out_res.trimmed;

  // a trimmed byte always closes the outgoing frame
  a_trim_is_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tlast)
    else $error("trimmed item without last");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid && s_tready)
    else $error("pipeline not empty after reset");

  // both registers full and output stalled: no further item may enter
  a_full_backpressure: assert property (@(posedge clk) disable iff (rst)
    in_valid && m_tvalid && !m_tready |-> !s_tready)
    else $error("item accepted while pipeline is full");

endmodule

@@ verif/ptp_delay_req_pad_trimmer_test.sv @@
// Self-checking testbench for the PTP Delay_Req pad trimmer, with a byte-level frame predictor.
`timescale 1ns / 1ps

module ptp_delay_req_pad_trimmer_test;
  import pdt_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  // Predicts the outgoing byte stream and holds the bytes still to come out.
  class trim_scoreboard;
    logic [DOMAIN_W-1:0] domain;
    logic [LEN_W-1:0]    ptp_len;
    logic [POS_W-1:0]    pos;
    bit                  vlan_seen;
    logic [7:0]          type_hi;
    logic [7:0]          len_hi;
    decision_t           decision;
    bit                  dropping;
    result_t             pending_bytes[$];
    int                  errors;

    function new();
      domain  = DOMAIN_RESET;
      ptp_len = LENGTH_RESET;
      errors  = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      pos       = '0;
      vlan_seen = 0;
      type_hi   = '0;
      len_hi    = '0;
      decision  = DEC_UNDECIDED;
      dropping  = 0;
    endfunction

    function void write_reg(cfg_index_t idx, logic [CFG_W-1:0] v);
      case (idx)
        CFG_PTP_DOMAIN: domain = v[DOMAIN_W-1:0];
        CFG_PTP_LENGTH: ptp_len = v[LEN_W-1:0];
        default: ;
      endcase
    endfunction

    function void parse_header(int unsigned p, logic [7:0] b);
      int unsigned hdr;
      logic [15:0] etype;
      int unsigned k;
      hdr = vlan_seen ? HDR_TAGGED : HDR_UNTAGGED;
      etype = {type_hi, b};
      if (p == 12) begin
        type_hi = b;
      end else if (p == 13) begin
        if (etype == ETYPE_VLAN_Q || etype == ETYPE_VLAN_AD) vlan_seen = 1;
        else if (etype != ETYPE_PTP) decision = DEC_PASS;
      end else if (vlan_seen && p == 16) begin
        type_hi = b;
      end else if (vlan_seen && p == 17) begin
        if (etype != ETYPE_PTP) decision = DEC_PASS;
      end else if (p >= hdr) begin
        k = p - hdr;
        case (k)
          0: if (b[3:0] != MSG_TYPE_DREQ) decision = DEC_PASS;
          1: if (b[3:0] != PTP_VERSION_2) decision = DEC_PASS;
          2: len_hi = b;
          3: if ({len_hi, b} != 16'(ptp_len)) decision = DEC_PASS;
          4: decision = (b == domain && ptp_len >= MIN_PTP_LENGTH) ? DEC_TRIM : DEC_PASS;
          default: ;
        endcase
      end
    endfunction

    function void note_input(logic [7:0] b, bit last);
      result_t r;
      int unsigned cut;
      if (dropping) begin
        if (last) clear_frame();
        return;
      end
      if (decision == DEC_UNDECIDED) parse_header(pos, b);
      r.data    = b;
      r.last    = last;
      r.trimmed = 1'b0;
      if (decision == DEC_TRIM && !last) begin
        cut = (vlan_seen ? HDR_TAGGED : HDR_UNTAGGED) + ptp_len;
        if (int'(pos) + 1 == cut) begin
          r.last    = 1'b1;
          r.trimmed = 1'b1;
          dropping  = 1;
        end
      end
      pending_bytes.push_back(r);
      if (pos != '1) pos++;
      if (last) clear_frame();
    endfunction

    function void check_result(logic [7:0] d, logic last, logic trimmed);
      result_t e;
      if (pending_bytes.size() == 0) begin
        $display("%0t: unexpected item data %02h last %0b trimmed %0b",
                 $time, d, last, trimmed);
        errors++;
        return;
      end
      e = pending_bytes.pop_front();
      if (d !== e.data) begin
        $display("%0t: data mismatch expected %02h actual %02h", $time, e.data, d);
        errors++;
      end
      if (last !== e.last) begin
        $display("%0t: last mismatch expected %0b actual %0b", $time, e.last, last);
        errors++;
      end
      if (trimmed !== e.trimmed) begin
        $display("%0t: trimmed mismatch expected %0b actual %0b", $time, e.trimmed, trimmed);
        errors++;
      end
    endfunction

    function int pending();
      return pending_bytes.size();
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [7:0]        s_tdata = '0;   // [7:0] data_byte
  logic              s_tlast = 1'b0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [7:0]        m_tdata;        // [7:0] out_byte
  logic              m_tlast;
  logic              m_tuser;        // [0] was_trimmed
  logic              cfg_we = 1'b0;
  logic [0:0]        cfg_index = '0;
  logic [CFG_W-1:0]  cfg_data = '0;

  trim_scoreboard    sb = new();
  logic [7:0]        frame_bytes[$];
  logic [7:0]        cur_dom;
  logic [LEN_W-1:0]  cur_len;
  bit                idle_on = 1;
  bit                hold_req = 0;
  int                hold_left = 0;
  int                stall_left = 0;
  int                n_sent = 0;
  int                cycles = 0;

  ptp_delay_req_pad_trimmer dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // Receiver: checks each accepted item and applies stalls.
  initial begin
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata, m_tlast, m_tuser);
      if (hold_req) begin
        hold_left = 80;
        hold_req  = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 5) - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  task automatic send_byte(input logic [7:0] d, input bit last);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= d;
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    sb.note_input(d, last);
    n_sent++;
  endtask

  task automatic send_frame();
    foreach (frame_bytes[i]) send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
  endtask

  task automatic build_frame(input bit with_tag, input logic [15:0] tag_type,
                             input logic [15:0] etype, input logic [7:0] msg,
                             input logic [7:0] ver, input logic [15:0] len_field,
                             input logic [7:0] dom, input int total);
    frame_bytes.delete();
    repeat (12) frame_bytes.push_back(8'($urandom));
    if (with_tag) begin
      frame_bytes.push_back(tag_type[15:8]);
      frame_bytes.push_back(tag_type[7:0]);
      repeat (2) frame_bytes.push_back(8'($urandom));
    end
    frame_bytes.push_back(etype[15:8]);
    frame_bytes.push_back(etype[7:0]);
    frame_bytes.push_back(msg);
    frame_bytes.push_back(ver);
    frame_bytes.push_back(len_field[15:8]);
    frame_bytes.push_back(len_field[7:0]);
    frame_bytes.push_back(dom);
    while (frame_bytes.size() < total) frame_bytes.push_back(8'($urandom));
    while (frame_bytes.size() > total) void'(frame_bytes.pop_back());
  endtask

  // Wait for the output to drain, then load both registers.
  task automatic set_config(input logic [7:0] dom, input logic [LEN_W-1:0] len);
    logic [CFG_W-1:0] dom_word;
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    // upper bits are don't-care for the domain register
    dom_word = {3'($urandom), dom};
    cfg_we    <= 1'b1;
    cfg_index <= CFG_PTP_DOMAIN;
    cfg_data  <= dom_word;
    @(posedge clk);
    sb.write_reg(CFG_PTP_DOMAIN, dom_word);
    cfg_index <= CFG_PTP_LENGTH;
    cfg_data  <= len;
    @(posedge clk);
    sb.write_reg(CFG_PTP_LENGTH, len);
    cfg_we <= 1'b0;
    cur_dom = dom;
    cur_len = len;
  endtask

  task automatic send_random_frame();
    bit          with_tag;
    logic [15:0] tag_type;
    logic [15:0] etype;
    logic [15:0] len_field;
    logic [7:0]  msg;
    logic [7:0]  ver;
    logic [7:0]  dom;
    int          hdr;
    int          cut;
    int          total;
    int          sel;
    with_tag  = $urandom_range(0, 1);
    tag_type  = $urandom_range(0, 1) ? ETYPE_VLAN_Q : ETYPE_VLAN_AD;
    etype     = ETYPE_PTP;
    msg       = {4'($urandom), MSG_TYPE_DREQ};
    ver       = {4'($urandom), PTP_VERSION_2};
    len_field = 16'(cur_len);
    dom       = cur_dom;
    hdr       = with_tag ? HDR_TAGGED : HDR_UNTAGGED;
    cut       = hdr + cur_len;
    sel       = $urandom_range(0, 99);
    if (sel < 55) begin
      case ($urandom_range(0, 9))
        0: total = cut;
        1: total = cut - $urandom_range(1, 5);
        default: total = cut + $urandom_range(1, 20);
      endcase
    end else if (sel < 80) begin
      total = cut + $urandom_range(0, 12);
      case ($urandom_range(0, 6))
        0: etype = 16'($urandom);
        1: etype = $urandom_range(0, 1) ? ETYPE_VLAN_Q : ETYPE_VLAN_AD;  // VLAN type where the PTP type belongs
        2: msg = 8'($urandom);
        3: ver = 8'($urandom);
        4: len_field = len_field ^ (16'h1 << $urandom_range(0, 15));
        5: dom = dom ^ (8'h1 << $urandom_range(0, 7));
        default: tag_type = 16'($urandom);
      endcase
    end else if (sel < 90) begin
      // short frame: ends no later than the byte that decides the header
      total = $urandom_range(1, hdr + 5);
    end else begin
      etype = 16'($urandom);
      total = $urandom_range(1, 80);
    end
    build_frame(with_tag, tag_type, etype, msg, ver, len_field, dom, total);
    send_frame();
  endtask

  task automatic random_frames(input int n);
    int target;
    target = n_sent + n;
    while (n_sent < target) send_random_frame();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: shortest legal cut in the top domain, then one-byte frames.
    set_config(8'hff, 11'd5);
    build_frame(0, ETYPE_VLAN_Q, ETYPE_PTP, {4'h0, MSG_TYPE_DREQ}, {4'h0, PTP_VERSION_2},
                16'd5, 8'hff, 21);
    frame_bytes[19] = 8'h00;
    frame_bytes[20] = 8'hff;
    send_frame();
    send_byte(8'h00, 1);
    send_byte(8'hff, 1);

    set_config(DOMAIN_RESET, LENGTH_RESET);
    hold_req = 1;
    random_frames(200);

    set_config(8'h00, LEN_W'($urandom_range(5, 40)));
    random_frames(180);

    // lengths below the minimum never trim
    set_config(8'($urandom), LEN_W'($urandom_range(0, 4)));
    random_frames(150);

    // tagged frame whose cut lies past byte 256
    set_config(8'($urandom), 11'd300);
    build_frame(1, ETYPE_VLAN_AD, ETYPE_PTP, {4'h3, MSG_TYPE_DREQ}, {4'h1, PTP_VERSION_2},
                16'd300, cur_dom, 18 + 300 + 2);
    send_frame();

    set_config(8'($urandom), 11'd1500);
    build_frame(0, ETYPE_VLAN_Q, ETYPE_PTP, {4'h0, MSG_TYPE_DREQ}, {4'h0, PTP_VERSION_2},
                16'd1500, cur_dom, 16);
    send_frame();

    set_config(8'hff, 11'd5);
    random_frames(180);

    set_config(8'($urandom), LEN_W'($urandom_range(6, 64)));
    random_frames(180);

    idle_on = 0;
    set_config(8'($urandom), LEN_W'($urandom_range(6, 64)));
    random_frames(150);
    idle_on = 1;

    set_config(8'($urandom), LEN_W'($urandom_range(6, 64)));
    hold_req = 1;
    random_frames(180);

    idle_on = 0;
    set_config(8'($urandom), LEN_W'($urandom_range(5, 64)));
    random_frames(230);

    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
